// File: rtl/core/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation core.
package bpc_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned IterWidth = 5;

   localparam logic [1:0] CSR_CAL_A = 2'd0;
   localparam logic [1:0] CSR_CAL_B = 2'd1;
   localparam logic [1:0] CSR_CAL_C = 2'd2;
   localparam logic [1:0] CSR_OSS   = 2'd3;

   localparam logic KIND_TEMP  = 1'b0;
   localparam logic KIND_PRESS = 1'b1;

   localparam logic [31:0] C_B6_OFFSET = 32'd4000;
   localparam logic [31:0] C_B4_BIAS   = 32'd32768;
   localparam logic [31:0] C_B7_SCALE  = 32'd50000;
   localparam logic [31:0] C_P_K1      = 32'd3038;
   localparam logic [31:0] C_P_K2      = 32'hFFFF_E343;  // -7357
   localparam logic [31:0] C_P_K3      = 32'd3791;
   localparam logic [31:0] C_P_MAX     = 32'd262143;
   localparam logic [31:0] C_T_MAX     = 32'd32767;
   localparam logic [31:0] C_T_MIN     = 32'hFFFF_8000;

   typedef struct packed {
      logic        kind;
      logic [23:0] raw_reading;
   } req_payload_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [15:0] temperature_tenths;
      logic [17:0]        pressure_pa;
      logic               divide_fault;
   } rsp_payload_type;

   typedef struct packed {
      logic                 start;
      logic [WordWidth-1:0] op_a;
      logic [WordWidth-1:0] op_b;
   } op_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [WordWidth-1:0] result;
   } op_stat_type;

endpackage

// File: rtl/core/bpc_mul.sv
// Bit-serial shift-add multiplier, low 32 bits of the product.
module bpc_mul import bpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  op_cmd_type  cmd,
   output op_stat_type stat
);

   logic                 busy_ff, busy_in;
   logic [IterWidth-1:0] cnt_ff, cnt_in;
   logic [WordWidth-1:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = cmd.op_a;
         b_in    = cmd.op_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[WordWidth-2:0], 1'b0};
         b_in   = {1'b0, b_ff[WordWidth-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == IterWidth'(WordWidth - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign stat.busy   = busy_ff;
   assign stat.done   = busy_ff && (cnt_ff == IterWidth'(WordWidth - 1));
   assign stat.result = acc_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start) else $error("multiplier restarted while busy");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> !busy_ff) else $error("multiplier still busy after done");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> cnt_ff == '0) else $error("multiplier count not cleared");

endmodule

// File: rtl/core/bpc_div.sv
// Bit-serial restoring divider for 32-bit unsigned operands.
module bpc_div import bpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  op_cmd_type  cmd,
   output op_stat_type stat
);

   logic                 busy_ff, busy_in;
   logic [IterWidth-1:0] cnt_ff, cnt_in;
   logic [WordWidth-1:0] q_ff, q_in, d_ff, d_in, rem_ff, rem_in;
   logic [WordWidth:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, q_ff[WordWidth-1]} - {1'b0, d_ff};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = cmd.op_a;
         d_in    = cmd.op_b;
         rem_in  = '0;
      end else if (busy_ff) begin
         // borrow clear means the shifted remainder covers the divisor
         if (!trial[WordWidth]) begin
            rem_in = trial[WordWidth-1:0];
            q_in   = {q_ff[WordWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WordWidth-2:0], q_ff[WordWidth-1]};
            q_in   = {q_ff[WordWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == IterWidth'(WordWidth - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign stat.busy   = busy_ff;
   assign stat.done   = busy_ff && (cnt_ff == IterWidth'(WordWidth - 1));
   assign stat.result = q_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start) else $error("divider restarted while busy");
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> cmd.op_b != '0) else $error("divider started with zero divisor");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> !busy_ff) else $error("divider still busy after done");

endmodule

// File: rtl/core/barometric_pressure_compensation_core.sv
// Barometric pressure compensation core: sequencer over serial mul/div units.
//
// Requests arrive on req_valid/req_stall/req_payload; one result per request
// leaves on rsp_valid/rsp_stall/rsp_payload. Calibration words and the
// oversampling setting are written through csr_wr_en/csr_index/csr_wdata;
// the user must write them only while the core is idle, which the core
// itself does not enforce. A temperature request runs two serial
// operations (a multiply and a divide) plus sequencer steps. A pressure
// request runs ten serial multiplies and one serial divide, each with its
// launch step, plus three plain steps. A zero divisor ends either request
// early with divide_fault set. One request is in work at a time.
// req_stall is high while a request is in work. A finished result sits in
// the output register; the next request is accepted while it waits, and a
// later finished result waits in the sequencer until that register frees.
// Reset (synchronous, active high) clears the calibration registers, the
// stored temperature term and the last pressure, and drops rsp_valid.
module barometric_pressure_compensation_core import bpc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_index,
   input  logic [63:0]     csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   localparam logic [4:0] STP_T0  = 5'd0;
   localparam logic [4:0] STP_T1  = 5'd1;
   localparam logic [4:0] STP_T2  = 5'd2;
   localparam logic [4:0] STP_P0  = 5'd3;
   localparam logic [4:0] STP_P1  = 5'd4;
   localparam logic [4:0] STP_P2  = 5'd5;
   localparam logic [4:0] STP_P3  = 5'd6;
   localparam logic [4:0] STP_P4  = 5'd7;
   localparam logic [4:0] STP_P5  = 5'd8;
   localparam logic [4:0] STP_P6  = 5'd9;
   localparam logic [4:0] STP_P7  = 5'd10;
   localparam logic [4:0] STP_P8  = 5'd11;
   localparam logic [4:0] STP_P9  = 5'd12;
   localparam logic [4:0] STP_P10 = 5'd13;
   localparam logic [4:0] STP_P11 = 5'd14;
   localparam logic [4:0] STP_P12 = 5'd15;
   localparam logic [4:0] STP_P13 = 5'd16;

   state_type state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [63:0] cal_a_ff, cal_a_in, cal_b_ff, cal_b_in;
   logic [31:0] cal_c_ff, cal_c_in;
   logic [1:0]  oss_ff, oss_in;
   logic        kind_ff, kind_in;
   logic [23:0] raw_ff, raw_in;
   logic [31:0] temp_ff, temp_in;
   logic [17:0] press_ff, press_in;
   logic        fault_ff, fault_in;
   logic [31:0] b6_ff, b6_in, sq_ff, sq_in, x1_ff, x1_in, x3_ff, x3_in;
   logic [31:0] b3_ff, b3_in, b4_ff, b4_in, p_ff, p_in;
   logic        neg_ff, neg_in, b7hi_ff, b7hi_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   op_cmd_type  mul_cmd, div_cmd;
   op_stat_type mul_stat, div_stat;

   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0] ac4, ac5, ac6;
   logic [31:0] prod, quot, ut, up, dvd, dvs, tmp_a, tmp_b, qv, t_full;
   logic        req_acc;

   assign ac1 = cal_a_ff[63:48];
   assign ac2 = cal_a_ff[47:32];
   assign ac3 = cal_a_ff[31:16];
   assign ac4 = cal_a_ff[15:0];
   assign ac5 = cal_b_ff[63:48];
   assign ac6 = cal_b_ff[47:32];
   assign b1  = cal_b_ff[31:16];
   assign b2  = cal_b_ff[15:0];
   assign mc  = cal_c_ff[31:16];
   assign md  = cal_c_ff[15:0];

   assign prod = mul_stat.result;
   assign quot = div_stat.result;
   assign ut   = {16'b0, raw_ff[15:0]};
   assign up   = 32'({8'b0, raw_ff} >> (4'd8 - {2'b0, oss_ff}));

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   bpc_mul u_mul (.clock(clock), .reset(reset), .cmd(mul_cmd), .stat(mul_stat));
   bpc_div u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .stat(div_stat));

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cal_a_in     = cal_a_ff;
      cal_b_in     = cal_b_ff;
      cal_c_in     = cal_c_ff;
      oss_in       = oss_ff;
      kind_in      = kind_ff;
      raw_in       = raw_ff;
      temp_in      = temp_ff;
      press_in     = press_ff;
      fault_in     = fault_ff;
      b6_in        = b6_ff;
      sq_in        = sq_ff;
      x1_in        = x1_ff;
      x3_in        = x3_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      p_in         = p_ff;
      neg_in       = neg_ff;
      b7hi_in      = b7hi_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mul_cmd      = '0;
      div_cmd      = '0;
      dvd          = '0;
      dvs          = '0;
      tmp_a        = '0;
      tmp_b        = '0;
      qv           = '0;
      t_full       = '0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CAL_A: cal_a_in = csr_wdata;
            CSR_CAL_B: cal_b_in = csr_wdata;
            CSR_CAL_C: cal_c_in = csr_wdata[31:0];
            CSR_OSS:   oss_in   = csr_wdata[1:0];
            default:   ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               kind_in  = req_payload.kind;
               raw_in   = req_payload.raw_reading;
               fault_in = 1'b0;
               step_in  = (req_payload.kind == KIND_PRESS) ? STP_P0 : STP_T0;
               state_in = ST_CALC;
            end
         end
         ST_WAIT: begin
            if (mul_stat.done || div_stat.done) begin
               state_in = ST_CALC;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               t_full = 32'($signed(temp_ff + 32'd8) >>> 4);
               rsp_in.result_kind = kind_ff;
               if ($signed(t_full) > $signed(C_T_MAX)) begin
                  rsp_in.temperature_tenths = C_T_MAX[15:0];
               end else if ($signed(t_full) < $signed(C_T_MIN)) begin
                  rsp_in.temperature_tenths = C_T_MIN[15:0];
               end else begin
                  rsp_in.temperature_tenths = t_full[15:0];
               end
               rsp_in.pressure_pa  = press_ff;
               rsp_in.divide_fault = fault_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_CALC: begin
            step_in = step_ff + 5'd1;
            unique case (step_ff)
               STP_T0: begin
                  mul_cmd = '{1'b1, ut - {16'b0, ac6}, {16'b0, ac5}};
                  state_in = ST_WAIT;
               end
               STP_T1: begin
                  tmp_a = 32'($signed(prod) >>> 15);
                  x1_in = tmp_a;
                  dvd   = {{5{mc[15]}}, mc, 11'b0};
                  dvs   = tmp_a + 32'(md);
                  if (dvs == '0) begin
                     fault_in = 1'b1;
                     temp_in  = tmp_a;
                     state_in = ST_DONE;
                  end else begin
                     neg_in  = dvd[31] ^ dvs[31];
                     div_cmd = '{1'b1, dvd[31] ? -dvd : dvd, dvs[31] ? -dvs : dvs};
                     state_in = ST_WAIT;
                  end
               end
               STP_T2: begin
                  temp_in  = x1_ff + (neg_ff ? -quot : quot);
                  state_in = ST_DONE;
               end
               STP_P0: begin
                  tmp_a    = temp_ff - C_B6_OFFSET;
                  b6_in    = tmp_a;
                  mul_cmd  = '{1'b1, tmp_a, tmp_a};
                  state_in = ST_WAIT;
               end
               STP_P1: begin
                  tmp_a    = 32'($signed(prod) >>> 12);
                  sq_in    = tmp_a;
                  mul_cmd  = '{1'b1, 32'(b2), tmp_a};
                  state_in = ST_WAIT;
               end
               STP_P2: begin
                  x1_in    = 32'($signed(prod) >>> 11);
                  mul_cmd  = '{1'b1, 32'(ac2), b6_ff};
                  state_in = ST_WAIT;
               end
               STP_P3: begin
                  x3_in    = x1_ff + 32'($signed(prod) >>> 11);
                  mul_cmd  = '{1'b1, 32'(ac3), b6_ff};
                  state_in = ST_WAIT;
               end
               STP_P4: begin
                  // B3 = (((AC1*4 + X3) << oss) + 2) / 4, truncating toward zero
                  tmp_a    = ({{14{ac1[15]}}, ac1, 2'b0} + x3_ff) << oss_ff;
                  tmp_b    = tmp_a + 32'd2;
                  b3_in    = 32'($signed(tmp_b + (tmp_b[31] ? 32'd3 : 32'd0)) >>> 2);
                  x1_in    = 32'($signed(prod) >>> 13);
                  mul_cmd  = '{1'b1, 32'(b1), sq_ff};
                  state_in = ST_WAIT;
               end
               STP_P5: begin
                  tmp_a = x1_ff + 32'($signed(prod) >>> 16) + 32'd2;
                  x3_in = 32'($signed(tmp_a) >>> 2);
               end
               STP_P6: begin
                  mul_cmd  = '{1'b1, {16'b0, ac4}, x3_ff + C_B4_BIAS};
                  state_in = ST_WAIT;
               end
               STP_P7: begin
                  b4_in    = prod >> 15;
                  mul_cmd  = '{1'b1, up - b3_ff, C_B7_SCALE >> oss_ff};
                  state_in = ST_WAIT;
               end
               STP_P8: begin
                  if (b4_ff == '0) begin
                     fault_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     b7hi_in  = prod[31];
                     div_cmd  = '{1'b1, prod[31] ? prod : {prod[30:0], 1'b0}, b4_ff};
                     state_in = ST_WAIT;
                  end
               end
               STP_P9: begin
                  qv       = b7hi_ff ? {quot[30:0], 1'b0} : quot;
                  p_in     = qv;
                  tmp_a    = 32'($signed(qv) >>> 8);
                  mul_cmd  = '{1'b1, tmp_a, tmp_a};
                  state_in = ST_WAIT;
               end
               STP_P10: begin
                  mul_cmd  = '{1'b1, prod, C_P_K1};
                  state_in = ST_WAIT;
               end
               STP_P11: begin
                  x1_in    = 32'($signed(prod) >>> 16);
                  mul_cmd  = '{1'b1, C_P_K2, p_ff};
                  state_in = ST_WAIT;
               end
               STP_P12: begin
                  x1_in = x1_ff + 32'($signed(prod) >>> 16) + C_P_K3;
               end
               STP_P13: begin
                  tmp_a = p_ff + 32'($signed(x1_ff) >>> 4);
                  if (tmp_a[31]) begin
                     press_in = '0;
                  end else if (tmp_a > C_P_MAX) begin
                     press_in = C_P_MAX[17:0];
                  end else begin
                     press_in = tmp_a[17:0];
                  end
                  state_in = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cal_a_ff     <= '0;
         cal_b_ff     <= '0;
         cal_c_ff     <= '0;
         oss_ff       <= '0;
         temp_ff      <= '0;
         press_ff     <= '0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cal_a_ff     <= cal_a_in;
         cal_b_ff     <= cal_b_in;
         cal_c_ff     <= cal_c_in;
         oss_ff       <= oss_in;
         temp_ff      <= temp_in;
         press_ff     <= press_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      raw_ff  <= raw_in;
      b6_ff   <= b6_in;
      sq_ff   <= sq_in;
      x1_ff   <= x1_in;
      x3_ff   <= x3_in;
      b3_ff   <= b3_in;
      b4_ff   <= b4_in;
      p_ff    <= p_in;
      neg_ff  <= neg_in;
      b7hi_ff <= b7hi_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy)) else $error("both serial units busy");
   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_CALC) else $error("accepted request not started");
   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |-> (mul_stat.busy || div_stat.busy))
      else $error("waiting with no unit running");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done step");

endmodule

// File: tb/barometric_pressure_compensation_core_test.sv
// Self-checking test of the pressure compensation core against a local predictor.
`timescale 1ns / 100ps

module barometric_pressure_compensation_core_test;
   import bpc_pkg::*;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en = 1'b0;
   logic [1:0]      csr_index = '0;
   logic [63:0]     csr_wdata = '0;

   barometric_pressure_compensation_core dut (.*);

   always #1 clock = ~clock;

   initial begin
      #20000000;
      $display("FAILURE");
      $finish;
   end

   // predictor copy of registers and state
   logic [63:0] cal_a, cal_b;
   logic [31:0] cal_c;
   logic [1:0]  oss;
   logic signed [31:0] b5_term;
   logic [17:0] press_last;

   rsp_payload_type expected_q[$];
   int mismatches = 0;
   int results_seen = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int n_temp = 0, n_press = 0, n_faults = 0;

   function automatic logic signed [31:0] s16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic signed [31:0] u16(logic [15:0] v);
      return {16'd0, v};
   endfunction

   // truncating signed divide, wrapping
   function automatic logic signed [31:0] tdiv(logic signed [31:0] a, logic signed [31:0] b);
      longint q;
      q = longint'(a) / longint'(b);
      return q[31:0];
   endfunction

   function automatic rsp_payload_type compensate(req_payload_type rq);
      rsp_payload_type r;
      logic signed [31:0] x1, x2, x3, b6, sq, b3, p, d, t;
      logic [31:0] b4, b7, q, up;
      logic [63:0] w;
      r = '0;
      r.result_kind = rq.kind;
      if (rq.kind == KIND_TEMP) begin
         x1 = $signed(({16'd0, rq.raw_reading[15:0]} - u16(cal_b[47:32]))
                      * u16(cal_b[63:48])) >>> 15;
         d = x1 + s16(cal_c[15:0]);
         if (d == 0) begin
            r.divide_fault = 1'b1;
            x2 = 0;
         end else
            x2 = tdiv(s16(cal_c[31:16]) * 32'sd2048, d);
         b5_term = x1 + x2;
      end else begin
         up = {8'd0, rq.raw_reading} >> (4'd8 - oss);
         b6 = b5_term - 32'sd4000;
         sq = (b6 * b6) >>> 12;
         x1 = (s16(cal_b[15:0]) * sq) >>> 11;
         x2 = (s16(cal_a[47:32]) * b6) >>> 11;
         x3 = x1 + x2;
         b3 = tdiv(((s16(cal_a[63:48]) * 4 + x3) << oss) + 2, 4);
         x1 = (s16(cal_a[31:16]) * b6) >>> 13;
         x2 = (s16(cal_b[31:16]) * sq) >>> 16;
         x3 = (x1 + x2 + 2) >>> 2;
         w = {32'd0, u16(cal_a[15:0])} * {32'd0, x3 + 32'sd32768};
         b4 = w[31:0] >> 15;
         b7 = (up - b3) * (32'd50000 >> oss);
         if (b4 == 0)
            r.divide_fault = 1'b1;
         else begin
            if (b7 < 32'h8000_0000)
               q = (b7 * 2) / b4;
            else
               q = (b7 / b4) * 2;
            p = q;
            x1 = p >>> 8;
            x1 = x1 * x1;
            x1 = (x1 * 32'sd3038) >>> 16;
            x2 = (-32'sd7357 * p) >>> 16;
            p = p + ((x1 + x2 + 32'sd3791) >>> 4);
            if (p < 0)
               press_last = '0;
            else if (p > 262143)
               press_last = 18'h3FFFF;
            else
               press_last = p[17:0];
         end
      end
      t = (b5_term + 8) >>> 4;
      if (t > 32767)
         t = 32767;
      else if (t < -32768)
         t = -32768;
      r.temperature_tenths = t[15:0];
      r.pressure_pa = press_last;
      return r;
   endfunction

   // response side: random stall and compare
   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %p", rsp_payload);
            end else begin
               e = expected_q.pop_front();
               if (rsp_payload !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p got %p", e, rsp_payload);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CAL_A: cal_a = val;
         CSR_CAL_B: cal_b = val;
         CSR_CAL_C: cal_c = val[31:0];
         CSR_OSS:   oss = val[1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // send one request; a typed-in expectation is used when given
   task automatic send_request(req_payload_type rq, bit typed, rsp_payload_type typed_rsp);
      rsp_payload_type pr;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pr = compensate(rq);
      expected_q.push_back(typed ? typed_rsp : pr);
      if (rq.kind == KIND_TEMP)
         n_temp++;
      else
         n_press++;
      if (pr.divide_fault)
         n_faults++;
   endtask

   typedef struct {
      req_payload_type rq;
      bit              typed;
      rsp_payload_type rsp;
   } stim_row_type;

   // datasheet example calibration
   localparam logic [63:0] CAL_A_TYP = {16'd408, -16'sd72, -16'sd14383, 16'd32741};
   localparam logic [63:0] CAL_B_TYP = {16'd32757, 16'd23153, 16'd6190, 16'd4};
   localparam logic [31:0] CAL_C_TYP = {-16'sd8711, 16'd2868};

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_cal(bit typical);
      if (typical) begin
         write_reg(CSR_CAL_A, CAL_A_TYP ^ {6'd0, 10'($urandom_range(1023)), 6'd0,
                   10'($urandom), 22'd0, 10'($urandom)});
         write_reg(CSR_CAL_B, CAL_B_TYP ^ {6'd0, 10'($urandom), 6'd0,
                   10'($urandom), 32'd0});
         write_reg(CSR_CAL_C, CAL_C_TYP ^ {6'd0, 10'($urandom), 6'd0, 10'($urandom)});
      end else begin
         write_reg(CSR_CAL_A, rand64());
         write_reg(CSR_CAL_B, rand64());
         write_reg(CSR_CAL_C, rand64());
      end
      write_reg(CSR_OSS, 64'($urandom_range(3)));
   endtask

   task automatic random_phase(int count);
      req_payload_type rq;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            wait_drained();
            random_cal(($urandom_range(3) != 0));
         end
         rq.kind = (i % 3 == 0) ? KIND_TEMP : KIND_PRESS;
         if ($urandom_range(9) == 0)
            rq.kind = 1'($urandom);
         if (rq.kind == KIND_TEMP)
            rq.raw_reading = ($urandom_range(3) == 0) ? 24'($urandom)
               : {8'($urandom), 16'(27898 + $urandom_range(8000) - 4000)};
         else
            rq.raw_reading = ($urandom_range(3) == 0) ? 24'($urandom)
               : 24'(23843 * 256 + $urandom_range(4000000) - 2000000);
         send_request(rq, 1'b0, '0);
      end
   endtask

   stim_row_type directed[$];
   stim_row_type row;

   // row checked against the predictor
   function automatic void add_row(logic kind, logic [23:0] raw);
      stim_row_type r;
      r.rq = '{kind, raw};
      r.typed = 1'b0;
      r.rsp = '0;
      directed.push_back(r);
   endfunction

   task automatic run_rows();
      foreach (directed[k])
         send_request(directed[k].rq, directed[k].typed, directed[k].rsp);
      directed.delete();
   endtask

   initial begin
      cal_a = '0;
      cal_b = '0;
      cal_c = '0;
      oss = '0;
      b5_term = '0;
      press_last = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset everything is zero: X1+MD is zero, and B4 is zero
      row.rq = '{KIND_TEMP, 24'hFF_FFFF};
      row.typed = 1;
      row.rsp = '{KIND_TEMP, 16'sd0, 18'd0, 1'b1};
      directed.push_back(row);
      row.rq = '{KIND_PRESS, 24'hFF_FFFF};
      row.rsp = '{KIND_PRESS, 16'sd0, 18'd0, 1'b1};
      directed.push_back(row);
      run_rows();
      wait_drained();

      // typical calibration, then typical and extreme readings at each oversampling
      write_reg(CSR_CAL_A, CAL_A_TYP);
      write_reg(CSR_CAL_B, CAL_B_TYP);
      write_reg(CSR_CAL_C, CAL_C_TYP);
      for (int o = 0; o < 4; o++) begin
         wait_drained();
         write_reg(CSR_OSS, 64'(o));
         add_row(KIND_TEMP, 24'd27898);
         add_row(KIND_PRESS, 24'd23843 << 8);
         add_row(KIND_PRESS, 24'h00_0000);
         add_row(KIND_PRESS, 24'hFF_FFFF);
         run_rows();
      end
      add_row(KIND_TEMP, 24'h00_0000);
      add_row(KIND_TEMP, 24'hAB_FFFF);
      add_row(KIND_PRESS, 24'h80_0000);
      run_rows();
      wait_drained();
      // extreme calibration words for saturation and wrap
      write_reg(CSR_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_CAL_C, 64'h7FFF_0001);
      add_row(KIND_TEMP, 24'h00_0000);
      add_row(KIND_PRESS, 24'hFF_FFFF);
      add_row(KIND_TEMP, 24'h00_FFFF);
      add_row(KIND_PRESS, 24'h00_0001);
      run_rows();
      wait_drained();
      write_reg(CSR_CAL_A, 64'h8000_8000_8000_0000);
      write_reg(CSR_CAL_B, 64'h0000_0000_8000_8000);
      write_reg(CSR_CAL_C, 64'h8000_8000);
      add_row(KIND_TEMP, 24'h00_8000);
      add_row(KIND_PRESS, 24'h12_3456);
      run_rows();
      wait_drained();

      send_idle_pct = 17;
      recv_idle_pct = 81;
      random_phase(480);
      wait_drained();  // sender holds off until all results are in
      send_idle_pct = 81;
      recv_idle_pct = 17;
      random_phase(480);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(460);
      wait_drained();

      $display("covered %0d temperature and %0d pressure requests, %0d divide faults,",
               n_temp, n_press, n_faults);
      $display("%0d results checked under three idle patterns and varied calibration",
               results_seen);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
